@@ rtl/stts_pkg.sv @@
// Shared types and constants for the sorted table tolerance search block.
package stts_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int IDX_W           = 10;
  localparam int LEN_W           = 11;
  localparam int TOL_W           = 31;
  localparam int STATUS_W        = 3;
  localparam int ADDR_W          = 3;

  // Register indexes on the configuration port.
  localparam logic REG_TABLE_LENGTH = 1'b0;
  localparam logic REG_TOLERANCE    = 1'b1;

  // Function codes of an input transaction.
  localparam logic [1:0] FN_LOAD    = 2'd0;
  localparam logic [1:0] FN_BRACKET = 2'd1;
  localparam logic [1:0] FN_FIRST   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_BELOW     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_ABOVE     = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BR_LO,
    S_BR_HI,
    S_BR_SRCH,
    S_BR_SCAN,
    S_BR_END,
    S_FM_SRCH,
    S_FM_START,
    S_FM_SCAN,
    S_HOLD
  } seq_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    lower;
    logic [IDX_W-1:0]    upper;
  } result_t;

endpackage

@@ rtl/sorted_table_tolerance_search.sv @@
// Sorted table search: holds up to TABLE_DEPTH signed Q16.16 entries in one
// synchronous memory and answers bracket and first-match queries against a
// tolerance. Items are handled one at a time, and the memory's single read port
// sets the pace: a probe reads one entry per cycle. A load or an unknown
// function passes its result through the hold state to the output register.
// A bracket query checks the first and last entries, then makes binary-search
// probes (at most ceil(log2(len+1))) and steps left over matching entries.
// A first-match query makes lower-bound probes (at most ceil(log2(len+1)))
// and then scans forward from the bound. A result waiting in the output
// register does not stop the next transaction from being accepted. The memory
// has no reset; a query must only touch entries that were loaded.
module sorted_table_tolerance_search
  import stts_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_func,
  input  logic [IDX_W-1:0]           in_entry_index,
  input  logic signed [31:0]         in_entry_value,
  input  logic signed [31:0]         in_query_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [IDX_W-1:0]           out_lower_index,
  output logic [IDX_W-1:0]           out_upper_index,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  // Table storage
  logic signed [31:0] table_mem [TABLE_DEPTH];
  logic signed [31:0] rdata_r;
  logic               rd_en;
  logic [NW-1:0]      rd_idx;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;

  // Configuration
  logic [LEN_W-1:0] table_length_r;
  logic [TOL_W-1:0] tolerance_r;
  logic             cfg_we;
  logic [NW-1:0]    len_w;

  // Sequencer
  seq_state_t         state_r, state_nxt;
  logic [NW-1:0]      len_r, len_nxt;
  logic [NW-1:0]      low_r, low_nxt;
  logic [NW-1:0]      high_r, high_nxt;
  logic [NW-1:0]      mid_r, mid_nxt;
  logic [NW-1:0]      cur_r, cur_nxt;
  logic signed [31:0] q_r, q_nxt;
  logic signed [32:0] lb_r, lb_nxt;
  logic signed [32:0] ub_r, ub_nxt;
  result_t            res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r;
  logic               out_load;

  // Datapath helpers
  logic signed [32:0] ext_e;
  logic               e_ge_lb;
  logic               e_le_ub;
  logic               e_lt_q;
  logic               hit;
  logic [NW-1:0]      up_base;
  logic [NW-1:0]      mid_up;
  logic [NW-1:0]      dn_top;
  logic [NW-1:0]      mid_dn_br;
  logic [NW-1:0]      mid_dn_fm;
  logic               bad_index;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
      tolerance_r    <= '0;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_TABLE_LENGTH: table_length_r <= pwdata[LEN_W-1:0];
        REG_TOLERANCE:    tolerance_r    <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TABLE_LENGTH: prdata = {{(32-LEN_W){1'b0}}, table_length_r};
      REG_TOLERANCE:    prdata = {{(32-TOL_W){1'b0}}, tolerance_r};
      default:          prdata = '0;
    endcase
  end

  // A length above the table depth is treated as the full table.
  assign len_w = (32'(table_length_r) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                         : NW'(table_length_r);

  // ---------------------------------------------------------------------------
  // Table memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  assign wr_addr = AW'(in_entry_index);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr] <= in_entry_value;
    end
    if (rd_en) begin
      rdata_r <= table_mem[rd_idx[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Compare and next-probe logic
  // ---------------------------------------------------------------------------
  // Within tolerance is the same as lb <= entry <= ub with exact 33-bit bounds.
  assign ext_e   = {rdata_r[31], rdata_r};
  assign e_ge_lb = ext_e >= lb_r;
  assign e_le_ub = ext_e <= ub_r;
  assign e_lt_q  = rdata_r < q_r;
  assign hit     = e_ge_lb && e_le_ub;

  // Both possible next midpoints are formed in parallel with the compare.
  assign up_base   = mid_r + NW'(1);
  assign mid_up    = up_base + ((high_r - up_base) >> 1);
  assign dn_top    = mid_r - NW'(1);
  assign mid_dn_br = low_r + ((dn_top - low_r) >> 1);
  assign mid_dn_fm = low_r + ((mid_r - low_r) >> 1);

  assign bad_index = 32'(in_entry_index) >= 32'(TABLE_DEPTH);

  assign in_ready = (state_r == S_IDLE);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    low_r  <= low_nxt;
    high_r <= high_nxt;
    mid_r  <= mid_nxt;
    cur_r  <= cur_nxt;
    q_r    <= q_nxt;
    lb_r   <= lb_nxt;
    ub_r   <= ub_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    mid_nxt   = mid_r;
    cur_nxt   = cur_r;
    q_nxt     = q_r;
    lb_nxt    = lb_r;
    ub_nxt    = ub_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_idx    = '0;
    mem_we    = 1'b0;
    out_load  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          len_nxt = len_w;
          q_nxt   = in_query_value;
          lb_nxt  = {in_query_value[31], in_query_value} - {2'b00, tolerance_r};
          ub_nxt  = {in_query_value[31], in_query_value} + {2'b00, tolerance_r};
          case (in_func)
            FN_LOAD: begin
              if (bad_index) begin
                res_nxt = '{STS_BAD_INDEX, in_entry_index, in_entry_index};
              end else begin
                mem_we  = 1'b1;
                res_nxt = '{STS_OK, in_entry_index, in_entry_index};
              end
              state_nxt = S_HOLD;
            end
            FN_BRACKET: begin
              if (len_w == '0) begin
                res_nxt   = '{STS_EMPTY, '0, '0};
                state_nxt = S_HOLD;
              end else begin
                rd_en     = 1'b1;
                rd_idx    = '0;
                state_nxt = S_BR_LO;
              end
            end
            FN_FIRST: begin
              if (len_w == '0) begin
                res_nxt   = '{STS_EMPTY, '0, '0};
                state_nxt = S_HOLD;
              end else begin
                low_nxt   = '0;
                high_nxt  = len_w;
                mid_nxt   = len_w >> 1;
                rd_en     = 1'b1;
                rd_idx    = len_w >> 1;
                state_nxt = S_FM_SRCH;
              end
            end
            default: begin
              res_nxt   = '{STS_BAD_INDEX, '0, '0};
              state_nxt = S_HOLD;
            end
          endcase
        end
      end

      // First entry is in rdata_r: below range when it exceeds query+tolerance.
      S_BR_LO: begin
        if (!e_le_ub) begin
          res_nxt   = '{STS_BELOW, '0, '0};
          state_nxt = S_HOLD;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = len_r - NW'(1);
          state_nxt = S_BR_HI;
        end
      end

      // Last entry is in rdata_r: above range when it is under query-tolerance.
      S_BR_HI: begin
        if (!e_ge_lb) begin
          res_nxt   = '{STS_ABOVE, '0, '0};
          state_nxt = S_HOLD;
        end else begin
          low_nxt   = '0;
          high_nxt  = len_r - NW'(1);
          mid_nxt   = (len_r - NW'(1)) >> 1;
          rd_en     = 1'b1;
          rd_idx    = (len_r - NW'(1)) >> 1;
          state_nxt = S_BR_SRCH;
        end
      end

      S_BR_SRCH: begin
        if (hit) begin
          if (mid_r == '0) begin
            res_nxt   = '{STS_OK, '0, '0};
            state_nxt = S_HOLD;
          end else begin
            cur_nxt   = mid_r;
            rd_en     = 1'b1;
            rd_idx    = dn_top;
            state_nxt = S_BR_SCAN;
          end
        end else if (e_lt_q) begin
          low_nxt = up_base;
          if (mid_r < high_r) begin
            mid_nxt = mid_up;
            rd_en   = 1'b1;
            rd_idx  = mid_up;
          end else begin
            state_nxt = S_BR_END;
          end
        end else if (mid_r == '0) begin
          state_nxt = S_BR_END;
        end else begin
          high_nxt = dn_top;
          if (low_r < mid_r) begin
            mid_nxt = mid_dn_br;
            rd_en   = 1'b1;
            rd_idx  = mid_dn_br;
          end else begin
            state_nxt = S_BR_END;
          end
        end
      end

      // rdata_r holds the entry just left of cur_r.
      S_BR_SCAN: begin
        if (hit) begin
          cur_nxt = cur_r - NW'(1);
          if (cur_r == NW'(1)) begin
            res_nxt   = '{STS_OK, '0, '0};
            state_nxt = S_HOLD;
          end else begin
            rd_en  = 1'b1;
            rd_idx = cur_r - NW'(2);
          end
        end else begin
          res_nxt   = '{STS_OK, IDX_W'(cur_r), IDX_W'(cur_r)};
          state_nxt = S_HOLD;
        end
      end

      // No match: report the insertion bracket, clamped to the table.
      S_BR_END: begin
        res_nxt.status = STS_OK;
        res_nxt.lower  = (low_r != '0) ? IDX_W'(low_r - NW'(1)) : '0;
        res_nxt.upper  = (low_r < len_r) ? IDX_W'(low_r) : IDX_W'(len_r - NW'(1));
        state_nxt      = S_HOLD;
      end

      // Lower-bound search for the first entry not below query-tolerance.
      S_FM_SRCH: begin
        if (!e_ge_lb) begin
          low_nxt = up_base;
          if (up_base < high_r) begin
            mid_nxt = mid_up;
            rd_en   = 1'b1;
            rd_idx  = mid_up;
          end else begin
            state_nxt = S_FM_START;
          end
        end else begin
          high_nxt = mid_r;
          if (low_r < mid_r) begin
            mid_nxt = mid_dn_fm;
            rd_en   = 1'b1;
            rd_idx  = mid_dn_fm;
          end else begin
            state_nxt = S_FM_START;
          end
        end
      end

      S_FM_START: begin
        if (low_r < len_r) begin
          cur_nxt   = low_r;
          rd_en     = 1'b1;
          rd_idx    = low_r;
          state_nxt = S_FM_SCAN;
        end else begin
          res_nxt   = '{STS_NOT_FOUND, '0, '0};
          state_nxt = S_HOLD;
        end
      end

      // Scan forward; entries below the window are skipped, one above ends it.
      S_FM_SCAN: begin
        if (!e_le_ub) begin
          res_nxt   = '{STS_NOT_FOUND, '0, '0};
          state_nxt = S_HOLD;
        end else if (e_ge_lb) begin
          res_nxt   = '{STS_OK, IDX_W'(cur_r), IDX_W'(cur_r)};
          state_nxt = S_HOLD;
        end else if ((cur_r + NW'(1)) < len_r) begin
          cur_nxt = cur_r + NW'(1);
          rd_en   = 1'b1;
          rd_idx  = cur_r + NW'(1);
        end else begin
          res_nxt   = '{STS_NOT_FOUND, '0, '0};
          state_nxt = S_HOLD;
        end
      end

      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_lower_index = out_r.lower;
  assign out_upper_index = out_r.upper;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Every read issued while a query is in flight stays inside the used table.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && state_r != S_IDLE) |-> (rd_idx < len_r))
    else $error("table read beyond the used length");

  // The probe of the bracket search always lies between its bounds.
  a_br_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BR_SRCH) |-> (low_r <= mid_r && mid_r <= high_r))
    else $error("bracket probe outside its search window");

  // The probe of the lower-bound search lies in the half-open window.
  a_fm_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FM_SRCH) |-> (low_r <= mid_r && mid_r < high_r))
    else $error("first-match probe outside its search window");

  // A staged result is not dropped while the output register is stalled.
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && out_valid_r && !out_ready) |=> (state_r == S_HOLD))
    else $error("staged result left while the output was stalled");

endmodule

@@ dv/sorted_table_tolerance_search_test.sv @@
// Self-checking testbench for the sorted table tolerance search block.
module sorted_table_tolerance_search_test
  import stts_pkg::*;
();

  localparam int     WATCHDOG_LIMIT = 20000;
  localparam int     ITEM_TARGET    = 1000;
  localparam longint Q_MAX          = 64'sd2147483647;
  localparam longint Q_MIN          = -64'sd2147483648;
  // Function code that the block does not implement.
  localparam logic [1:0] FN_UNUSED  = 2'd3;

  typedef enum logic {ROW_TXN, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               reg_sel;
    logic [31:0]        reg_val;
    logic [1:0]         func;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        ev;
    logic [31:0]        qv;
    logic               typed;
    result_t            res;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_func;
  logic [IDX_W-1:0]     in_entry_index;
  logic signed [31:0]   in_entry_value;
  logic signed [31:0]   in_query_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  out_status;
  logic [IDX_W-1:0]     out_lower_index;
  logic [IDX_W-1:0]     out_upper_index;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  // Mirror of the block's table and registers.
  logic signed [31:0]   table_copy [TABLE_DEPTH_DEF];
  logic [LEN_W-1:0]     length_setting;
  logic [TOL_W-1:0]     tol_setting;
  result_t              pending_results [$];

  int err_count    = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;

  sorted_table_tolerance_search u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_query_value  (in_query_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_lower_index (out_lower_index),
    .out_upper_index (out_upper_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t mk_res(logic [STATUS_W-1:0] st, longint lo, longint hi);
    result_t r;
    r.status = st;
    r.lower  = lo[IDX_W-1:0];
    r.upper  = hi[IDX_W-1:0];
    return r;
  endfunction

  function automatic longint entry_val(longint i);
    if (i < 0 || i >= TABLE_DEPTH_DEF) return 0;
    return longint'(table_copy[i]);
  endfunction

  function automatic bit near(longint e, longint q, longint tol);
    longint d;
    d = e - q;
    if (d < 0) d = -d;
    return d <= tol;
  endfunction

  function automatic longint used_len();
    longint n;
    n = length_setting;
    if (n > TABLE_DEPTH_DEF) n = TABLE_DEPTH_DEF;
    return n;
  endfunction

  function automatic result_t bracket_outcome(longint q);
    longint len, tol, low, high, mid, e, lower, upper;
    len = used_len();
    tol = tol_setting;
    if (len == 0) return mk_res(STS_EMPTY, 0, 0);
    if (q < entry_val(0) - tol) return mk_res(STS_BELOW, 0, 0);
    if (q > entry_val(len - 1) + tol) return mk_res(STS_ABOVE, 0, 0);
    low  = 0;
    high = len - 1;
    while (low <= high) begin
      mid = low + (high - low) / 2;
      e   = entry_val(mid);
      if (near(e, q, tol)) begin
        // Walk back to the earliest entry that still matches.
        while (mid > 0 && near(entry_val(mid - 1), q, tol)) mid--;
        return mk_res(STS_OK, mid, mid);
      end else if (e < q) begin
        low = mid + 1;
      end else begin
        if (mid == 0) break;
        high = mid - 1;
      end
    end
    lower = (low > 0) ? low - 1 : 0;
    upper = (low < len) ? low : len - 1;
    return mk_res(STS_OK, lower, upper);
  endfunction

  function automatic result_t first_match_outcome(longint q);
    longint len, tol, lb, ub, low, high, mid, i, e;
    len  = used_len();
    tol  = tol_setting;
    lb   = q - tol;
    ub   = q + tol;
    low  = 0;
    high = len;
    if (len == 0) return mk_res(STS_EMPTY, 0, 0);
    while (low < high) begin
      mid = low + (high - low) / 2;
      if (entry_val(mid) < lb) low = mid + 1;
      else high = mid;
    end
    for (i = low; i < len; i++) begin
      e = entry_val(i);
      if (e > ub) break;
      if (near(e, q, tol)) return mk_res(STS_OK, i, i);
    end
    return mk_res(STS_NOT_FOUND, 0, 0);
  endfunction

  function automatic result_t search_outcome(logic [1:0] func, logic [IDX_W-1:0] idx,
                                             logic signed [31:0] ev,
                                             logic signed [31:0] qv);
    case (func)
      FN_LOAD: begin
        table_copy[idx] = ev;
        return mk_res(STS_OK, idx, idx);
      end
      FN_BRACKET: return bracket_outcome(qv);
      FN_FIRST:   return first_match_outcome(qv);
      default:    return mk_res(STS_BAD_INDEX, 0, 0);
    endcase
  endfunction

  function automatic stim_row_t row_txn(logic [1:0] func, logic [IDX_W-1:0] idx,
                                        logic [31:0] ev, logic [31:0] qv, logic typed,
                                        logic [STATUS_W-1:0] st, logic [IDX_W-1:0] lo,
                                        logic [IDX_W-1:0] hi);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_TXN;
    row.func    = func;
    row.idx     = idx;
    row.ev      = ev;
    row.qv      = qv;
    row.typed   = typed;
    row.res     = mk_res(st, lo, hi);
    return row;
  endfunction

  function automatic stim_row_t row_cfg(logic sel, logic [31:0] val);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  task automatic push_txn(input logic [1:0] func, input logic [IDX_W-1:0] idx,
                          input logic signed [31:0] ev, input logic signed [31:0] qv,
                          input bit typed, input result_t typed_res);
    int      gap;
    result_t pred;
    gap = 0;
    if (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(0, 99) < 33)
      gap = $urandom_range(1, 2);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_entry_index <= idx;
    in_entry_value <= ev;
    in_query_value <= qv;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    pred = search_outcome(func, idx, ev, qv);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Stop offering transactions and wait until every result is out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_TABLE_LENGTH) length_setting = val[LEN_W-1:0];
    else tol_setting = val[TOL_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Loads entries 0..n-1 with a sorted run; mode sets how tightly they cluster.
  task automatic fill_table(input int n, input int mode);
    longint cur, span;
    int     i;
    case (mode)
      0: begin
        cur  = longint'($signed($urandom));
        span = 2;
      end
      1: begin
        cur  = longint'($signed($urandom));
        span = 3 * 65536;
      end
      default: begin
        cur  = Q_MIN + longint'($urandom_range(0, 1 << 20));
        span = 64'sd6442450944 / n;
      end
    endcase
    if (span > 64'sd4294967295) span = 64'sd4294967295;
    for (i = 0; i < n; i++) begin
      push_txn(FN_LOAD, i[IDX_W-1:0], cur[31:0], $urandom, 1'b0, '0);
      cur = cur + longint'($urandom_range(0, 32'(span)));
      if (cur > Q_MAX) cur = Q_MAX;
    end
  endtask

  task automatic run_queries(input int count);
    int         c, r, k;
    longint     used, tol, q, w, e;
    logic [1:0] func;
    for (c = 0; c < count; c++) begin
      used = used_len();
      tol  = tol_setting;
      r    = $urandom_range(0, 99);
      if (r < 6) begin
        push_txn(FN_LOAD, IDX_W'($urandom), $urandom, $urandom, 1'b0, '0);
      end else if (r < 10) begin
        push_txn(FN_UNUSED, IDX_W'($urandom), $urandom, $urandom, 1'b0, '0);
      end else begin
        r = $urandom_range(0, 99);
        if (used == 0 || r < 10) begin
          q = longint'($signed($urandom));
        end else if (r < 14) begin
          q = Q_MIN;
        end else if (r < 18) begin
          q = Q_MAX;
        end else begin
          // Aim near a held entry so that matches, misses and scans all occur.
          k = $urandom_range(0, 32'(used - 1));
          e = longint'(table_copy[k]);
          case ($urandom_range(0, 5))
            0: q = e;
            1: q = e - tol;
            2: q = e + tol;
            3: q = $urandom_range(0, 1) ? e + tol + 1 : e - tol - 1;
            4: q = (k + 1 < used) ? (e + longint'(table_copy[k + 1])) / 2 : e + 1;
            default: begin
              w = tol + 2;
              if (w > Q_MAX) w = Q_MAX;
              q = e + longint'($urandom_range(0, 32'(2 * w))) - w;
            end
          endcase
          if (q < Q_MIN) q = Q_MIN;
          if (q > Q_MAX) q = Q_MAX;
        end
        func = $urandom_range(0, 1) ? FN_BRACKET : FN_FIRST;
        push_txn(func, IDX_W'($urandom), $urandom, q[31:0], 1'b0, '0);
      end
    end
  endtask

  // Result side: random back-pressure, one long hold-off and a clean stretch.
  initial begin : result_side
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (500) @(negedge clk);
      end else if (results_seen >= 700 && results_seen < 1000) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: status %0d lower %0d upper %0d", $time,
                 out_status, out_lower_index, out_upper_index);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_lower_index !== want.lower ||
            out_upper_index !== want.upper) begin
          err_count++;
          $display("%0t: mismatch: expected status %0d lower %0d upper %0d, got %0d %0d %0d",
                   $time, want.status, want.lower, want.upper,
                   out_status, out_lower_index, out_upper_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("sorted_table_tolerance_search verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   rows [$];
    stim_row_t   row;
    int          n, r;
    logic [31:0] len_val, tol_val;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FN_LOAD;
    in_entry_index = '0;
    in_entry_value = '0;
    in_query_value = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    length_setting = '0;
    tol_setting    = '0;

    // Empty table, unknown function, then a small table with extreme values.
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 0, 1, STS_EMPTY, 0, 0));
    rows.push_back(row_txn(FN_FIRST, 0, 0, 32'h8000_0000, 1, STS_EMPTY, 0, 0));
    rows.push_back(row_txn(FN_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                           STS_BAD_INDEX, 0, 0));
    rows.push_back(row_txn(FN_LOAD, 0, 32'h8000_0000, 0, 1, STS_OK, 0, 0));
    rows.push_back(row_txn(FN_LOAD, 1, 32'hFFFF_FFFF, 0, 1, STS_OK, 1, 1));
    rows.push_back(row_txn(FN_LOAD, 2, 0, 32'h7FFF_FFFF, 1, STS_OK, 2, 2));
    rows.push_back(row_txn(FN_LOAD, 3, 0, 0, 1, STS_OK, 3, 3));
    rows.push_back(row_txn(FN_LOAD, 4, 32'h0001_0000, 0, 1, STS_OK, 4, 4));
    rows.push_back(row_txn(FN_LOAD, 5, 32'h7FFF_FFFF, 0, 1, STS_OK, 5, 5));
    rows.push_back(row_txn(FN_LOAD, 10'h3FF, 32'h7FFF_FFFF, 0, 1, STS_OK, 10'h3FF, 10'h3FF));
    rows.push_back(row_cfg(REG_TABLE_LENGTH, 6));
    rows.push_back(row_cfg(REG_TOLERANCE, 0));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 32'h8000_0000, 0, STS_OK, 0, 0));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 0, 0, STS_OK, 0, 0));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 32'h0000_8000, 0, STS_OK, 0, 0));
    rows.push_back(row_txn(FN_FIRST, 0, 0, 0, 0, STS_OK, 0, 0));
    rows.push_back(row_txn(FN_FIRST, 0, 0, 1, 0, STS_OK, 0, 0));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 32'h7FFF_FFFF, 0, STS_OK, 0, 0));
    rows.push_back(row_cfg(REG_TOLERANCE, 32'h7FFF_FFFF));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 32'h7FFF_FFFF, 0, STS_OK, 0, 0));
    rows.push_back(row_txn(FN_FIRST, 0, 0, 32'h8000_0000, 0, STS_OK, 0, 0));
    rows.push_back(row_txn(FN_FIRST, 0, 0, 32'h7FFF_FFFF, 0, STS_OK, 0, 0));
    rows.push_back(row_cfg(REG_TOLERANCE, 1));
    // Raising the first entry and lowering the last leaves the table unsorted.
    rows.push_back(row_txn(FN_LOAD, 0, -5, 0, 1, STS_OK, 0, 0));
    rows.push_back(row_txn(FN_LOAD, 5, 100, 0, 1, STS_OK, 5, 5));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 32'h8000_0000, 1, STS_BELOW, 0, 0));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 32'h7FFF_FFFF, 1, STS_ABOVE, 0, 0));
    rows.push_back(row_txn(FN_FIRST, 0, 0, -3, 0, STS_OK, 0, 0));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 50, 0, STS_OK, 0, 0));
    // Lengths at and above the depth: these queries touch only the first and last entries.
    rows.push_back(row_txn(FN_LOAD, 10'h3FF, 0, 0, 1, STS_OK, 10'h3FF, 10'h3FF));
    rows.push_back(row_cfg(REG_TABLE_LENGTH, 32'h0000_07FF));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 32'h8000_0000, 1, STS_BELOW, 0, 0));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 32'h7FFF_FFFF, 1, STS_ABOVE, 0, 0));
    rows.push_back(row_cfg(REG_TABLE_LENGTH, TABLE_DEPTH_DEF));
    rows.push_back(row_txn(FN_BRACKET, 0, 0, 32'h7FFF_FFFF, 1, STS_ABOVE, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        cfg_write(row.reg_sel, row.reg_val);
      end else begin
        push_txn(row.func, row.idx, row.ev, row.qv, row.typed, row.res);
      end
    end

    // The length never exceeds the freshly loaded run, so only loaded entries are read.
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 19);
      if (r < 3) n = 1;
      else if (r < 5) n = 2;
      else n = $urandom_range(3, 40);

      r = $urandom_range(0, 19);
      if (r == 0) len_val = 0;
      else if (r == 1) len_val = $urandom_range(1, n);
      else len_val = n;

      case ($urandom_range(0, 9))
        0:       tol_val = 0;
        1:       tol_val = 32'h7FFF_FFFF;
        2:       tol_val = 1;
        3, 4:    tol_val = $urandom_range(0, 4);
        5, 6:    tol_val = $urandom_range(0, 4) << 16;
        7, 8:    tol_val = $urandom_range(0, 1 << 20);
        default: tol_val = $urandom;
      endcase

      settle();
      cfg_write(REG_TABLE_LENGTH, len_val);
      cfg_write(REG_TOLERANCE, tol_val);
      fill_table(n, $urandom_range(0, 2));
      run_queries($urandom_range(20, 50));
    end

    settle();
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("sorted_table_tolerance_search verification clean");
    end else begin
      $display("sorted_table_tolerance_search verification failed");
    end
    $finish;
  end

endmodule
